[rtl/kwm_pkg.sv]
// Shared types and constants for the k-way merge min-select block.
`default_nettype none

package kwm_pkg;

    localparam int MAX_RUNS   = 8;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_RUNS);
    localparam int CNT_W      = $clog2(MAX_RUNS + 1);

    localparam logic [3:0] RUN_COUNT_RESET = 4'd8;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [2:0]         run_index;
        logic signed [31:0] head_value;
        logic               run_exhausted;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] least_value;
        logic [2:0]         min_run;
        logic               merge_done;
    } result_t;

    // Write controls from the sequencer into the run store
    typedef struct packed {
        logic             refill_en;
        logic             refill_exh;
        logic [IDX_W-1:0] refill_idx;
        value_t           refill_val;
        logic             take_en;
        logic [IDX_W-1:0] take_idx;
    } store_ctl_t;

endpackage

`default_nettype wire

[rtl/kwm_cfg.sv]
// APB register slave holding run_count and the clamped active run count.
`default_nettype none

module kwm_cfg import kwm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CNT_W-1:0] active_cnt
);

    logic [3:0] run_count_reg;
    logic [3:0] run_count_next;
    logic       wr_en;

    // single register: every word address lands on run_count
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
    assign pready = 1'b1;
    assign prdata = 32'(run_count_reg);

    always_comb
    begin
        run_count_next = run_count_reg;
        if (wr_en)
        begin
            run_count_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= RUN_COUNT_RESET;
        end
        else
        begin
            run_count_reg <= run_count_next;
        end
    end

    // zero acts as one, anything past the run store acts as full
    always_comb
    begin
        if (run_count_reg == 4'd0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (int'(run_count_reg) > MAX_RUNS)
        begin
            active_cnt = CNT_W'(MAX_RUNS);
        end
        else
        begin
            active_cnt = CNT_W'(run_count_reg);
        end
    end

endmodule

`default_nettype wire

[rtl/kwm_run_store.sv]
// Per-run head values, valid flags and refill-wait flags with one scan read port.
`default_nettype none

module kwm_run_store import kwm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  store_ctl_t       ctl,
    input  logic [CNT_W-1:0] active_cnt,
    input  logic [IDX_W-1:0] rd_idx,
    output value_t           rd_value,
    output logic             rd_valid,
    output logic             any_wait
);

    value_t              head_reg [MAX_RUNS];
    logic [MAX_RUNS-1:0] valid_reg;
    logic [MAX_RUNS-1:0] valid_next;
    logic [MAX_RUNS-1:0] wait_reg;
    logic [MAX_RUNS-1:0] wait_next;
    logic [MAX_RUNS-1:0] active_mask;
    logic                refill_hit;

    // a refill only lands on a run that is waiting for one
    assign refill_hit = ctl.refill_en && wait_reg[ctl.refill_idx];

    always_ff @(posedge clk)
    begin
        if (refill_hit && !ctl.refill_exh)
        begin
            head_reg[ctl.refill_idx] <= ctl.refill_val;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        wait_next  = wait_reg;
        if (refill_hit)
        begin
            wait_next[ctl.refill_idx]  = 1'b0;
            valid_next[ctl.refill_idx] = !ctl.refill_exh;
        end
        if (ctl.take_en)
        begin
            wait_next[ctl.take_idx]  = 1'b1;
            valid_next[ctl.take_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wait_reg  <= '1;
        end
        else
        begin
            valid_reg <= valid_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RUNS; i++)
        begin
            active_mask[i] = (CNT_W'(i) < active_cnt);
        end
    end

    assign any_wait = |(wait_reg & active_mask);
    assign rd_value = head_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

endmodule

`default_nettype wire

[rtl/kwm_cmp.sv]
// Shared signed comparator deciding whether the scanned head beats the best so far.
`default_nettype none

module kwm_cmp import kwm_pkg::*; (
    input  value_t cand_value,
    input  logic   cand_valid,
    input  value_t best_value,
    input  logic   best_found,
    output logic   take
);

    logic less;

    // strict compare: on a tie the earlier (lower) run stays
    assign less = (cand_value < best_value);
    assign take = cand_valid && (!best_found || less);

endmodule

`default_nettype wire

[rtl/k_way_merge_min_select.sv]
// Top level: sequencer scanning run heads through one shared comparator.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  item in  | start, busy, item                       | beat when start && !busy
//  result   | result_valid, result                    | one-cycle strobe, no backpressure
//  config   | psel, penable, pwrite, paddr, pwdata,   | APB write, pready tied high
//           | prdata, pready                          |
//
// An item passes one accept and one wait check; if some active run still awaits a
// refill it returns to idle with no result, else n scan steps (n = active runs)
// follow through the single comparator; the result strobes in the cycle after the
// last scan step. busy is low during that strobe, so the next beat can be taken there.
// Reset clears valid flags and marks every run waiting; heads are unset.
// The result receiver cannot stall.
`default_nettype none

module k_way_merge_min_select import kwm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        result_valid,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    value_t           best_val_reg;
    value_t           best_val_next;
    logic             strobe_reg;
    logic             strobe_next;
    result_t          result_reg;
    result_t          result_next;

    logic [CNT_W-1:0] active_cnt;
    store_ctl_t       ctl;
    value_t           rd_value;
    logic             rd_valid;
    logic             any_wait;
    logic             take;
    logic             accept;
    logic             in_range;
    logic             last_step;
    logic             fin_found;
    logic [IDX_W-1:0] fin_idx;
    value_t           fin_val;

    kwm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .active_cnt (active_cnt)
    );

    kwm_run_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .active_cnt (active_cnt),
        .rd_idx     (idx_reg),
        .rd_value   (rd_value),
        .rd_valid   (rd_valid),
        .any_wait   (any_wait)
    );

    kwm_cmp u_cmp (
        .cand_value (rd_value),
        .cand_valid (rd_valid),
        .best_value (best_val_reg),
        .best_found (found_reg),
        .take       (take)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign in_range  = (int'(item.run_index) < int'(active_cnt));
    assign last_step = ((CNT_W'(idx_reg) + CNT_W'(1)) == active_cnt);

    assign fin_found = found_reg || take;
    assign fin_idx   = take ? idx_reg : best_idx_reg;
    assign fin_val   = take ? rd_value : best_val_reg;

    always_comb
    begin
        ctl.refill_en  = accept && in_range;
        ctl.refill_exh = item.run_exhausted;
        ctl.refill_idx = IDX_W'(item.run_index);
        ctl.refill_val = VALUE_BITS'(item.head_value);
        ctl.take_en    = (state_reg == ST_SCAN) && last_step && fin_found;
        ctl.take_idx   = fin_idx;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                state_next = any_wait ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN:
            begin
                idx_next      = idx_reg + IDX_W'(1);
                found_next    = fin_found;
                best_idx_next = fin_idx;
                best_val_next = fin_val;
                if (last_step)
                begin
                    state_next  = ST_IDLE;
                    strobe_next = 1'b1;
                    if (fin_found)
                    begin
                        result_next.least_value = 32'($unsigned(fin_val));
                        result_next.min_run     = 3'(fin_idx);
                        result_next.merge_done  = 1'b0;
                    end
                    else
                    begin
                        result_next.least_value = '0;
                        result_next.min_run     = '0;
                        result_next.merge_done  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        result_reg   <= result_next;
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[rtl/kwm_checker.sv]
// Port-level checker for the merge block, bound to the top level.
`default_nettype none

module kwm_checker import kwm_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input result_t     result,
    input logic        pready
);

    // every accepted beat occupies the block for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // results come one at a time, never back to back
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // a result only follows a busy period and strobes while idle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && $past(busy))
        else $error("result strobe outside the end of an item");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.merge_done |-> (result.least_value == 32'sd0)
            && (result.min_run == 3'd0))
        else $error("done result carries a value");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind k_way_merge_min_select kwm_checker u_kwm_checker (.*);

`default_nettype wire
